[rtl/core/vdp_hp_pkg.sv]
// Shared types and constants for the video display processor host port.
// No dependencies.
`timescale 1ns / 1ps

package vdp_hp_pkg;

    localparam int PTR_W  = 14;
    localparam int BYTE_W = 8;
    localparam int RIDX_W = 3;

    localparam int BIT_REG_SEL     = 7;
    localparam int BIT_NO_PREFETCH = 6;
    localparam int ADDR_HI_W       = 6;

    localparam logic [BYTE_W-1:0] STATUS_KEEP_MASK = 8'h7f;

    typedef enum logic [2:0] {
        CMD_RD_DATA   = 3'd0,
        CMD_RD_STATUS = 3'd1,
        CMD_WR_DATA   = 3'd2,
        CMD_WR_CTRL   = 3'd3,
        CMD_STS_EVENT = 3'd4
    } host_cmd_t;

    typedef struct packed {
        logic clr_step;
        logic start;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/core/vdp_hp_ctrl.sv]
// Host port controller: memory clear sequencing and per-beat execution FSM.
// Depends on vdp_hp_pkg.
`timescale 1ns / 1ps

module vdp_hp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  vdp_hp_pkg::dp_sts_t sts,
    output vdp_hp_pkg::dp_cmd_t cmd
);
    import vdp_hp_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.clr_step = 1'b0;
        cmd.start    = 1'b0;
        cmd.finish   = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[rtl/core/vdp_hp_dp.sv]
// Host port datapath: video memory, pointer, read-ahead, control latch,
// status byte and output register. Depends on vdp_hp_pkg.
`timescale 1ns / 1ps

module vdp_hp_dp #(
    parameter int VRAM_DEPTH = 16384
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vdp_hp_pkg::dp_cmd_t cmd,
    output vdp_hp_pkg::dp_sts_t sts,
    input  logic [2:0]          in_cmd,
    input  logic [7:0]          in_data,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [23:0]         m_tdata,   // read_data[7:0], reg_index[10:8], reg_value[18:11]
    output logic                m_tuser    // reg_written
);
    import vdp_hp_pkg::*;

    localparam int AW = $clog2(VRAM_DEPTH);

    logic [BYTE_W-1:0] vram [VRAM_DEPTH];
    logic [BYTE_W-1:0] mem_rdata_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              mem_re;
    logic              mem_we;

    logic [AW-1:0]     clr_cnt_reg;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [PTR_W-1:0]  new_ptr;
    logic [BYTE_W-1:0] ahead_reg;
    logic [BYTE_W-1:0] latch_reg, latch_next;
    logic              second_reg, second_next;
    logic [BYTE_W-1:0] status_reg, status_next;

    logic [BYTE_W-1:0] pend_rd_reg, pend_rd_next;
    logic              pend_rw_reg, pend_rw_next;
    logic [RIDX_W-1:0] pend_ri_reg, pend_ri_next;
    logic [BYTE_W-1:0] pend_rv_reg, pend_rv_next;
    logic              pend_fill_reg, pend_fill_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_rd_reg;
    logic              out_rw_reg;
    logic [RIDX_W-1:0] out_ri_reg;
    logic [BYTE_W-1:0] out_rv_reg;

    assign new_ptr = {in_data[ADDR_HI_W-1:0], latch_reg};

    always_comb
    begin
        ptr_next       = ptr_reg;
        latch_next     = latch_reg;
        second_next    = second_reg;
        status_next    = status_reg;
        pend_rd_next   = '0;
        pend_rw_next   = 1'b0;
        pend_ri_next   = '0;
        pend_rv_next   = '0;
        pend_fill_next = 1'b0;
        rd_addr        = ptr_reg[AW-1:0];
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = ptr_reg[AW-1:0];
        wr_data        = in_data;
        if (cmd.clr_step)
        begin
            mem_we  = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (cmd.start)
        begin
            unique case (in_cmd)
                CMD_RD_DATA:
                begin
                    second_next    = 1'b0;
                    pend_rd_next   = ahead_reg;
                    pend_fill_next = 1'b1;
                    mem_re         = 1'b1;
                    ptr_next       = ptr_reg + PTR_W'(1);
                end
                CMD_RD_STATUS:
                begin
                    second_next  = 1'b0;
                    pend_rd_next = status_reg;
                    status_next  = status_reg & STATUS_KEEP_MASK;
                end
                CMD_WR_DATA:
                begin
                    second_next = 1'b0;
                    mem_we      = 1'b1;
                    ptr_next    = ptr_reg + PTR_W'(1);
                end
                CMD_WR_CTRL:
                begin
                    if (!second_reg)
                    begin
                        latch_next  = in_data;
                        second_next = 1'b1;
                    end
                    else
                    begin
                        second_next = 1'b0;
                        if (in_data[BIT_REG_SEL])
                        begin
                            pend_rw_next = 1'b1;
                            pend_ri_next = in_data[RIDX_W-1:0];
                            pend_rv_next = latch_reg;
                        end
                        else if (in_data[BIT_NO_PREFETCH])
                        begin
                            ptr_next = new_ptr;
                        end
                        else
                        begin
                            rd_addr        = new_ptr[AW-1:0];
                            mem_re         = 1'b1;
                            pend_fill_next = 1'b1;
                            ptr_next       = new_ptr + PTR_W'(1);
                        end
                    end
                end
                CMD_STS_EVENT:
                begin
                    status_next = in_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vram[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= vram[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            ptr_reg       <= '0;
            ahead_reg     <= '0;
            latch_reg     <= '0;
            second_reg    <= 1'b0;
            status_reg    <= '0;
            pend_fill_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            ptr_reg    <= ptr_next;
            latch_reg  <= latch_next;
            second_reg <= second_next;
            status_reg <= status_next;
            if (cmd.start)
            begin
                pend_fill_reg <= pend_fill_next;
            end
            if (cmd.finish && pend_fill_reg)
            begin
                ahead_reg <= mem_rdata_reg;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pend_rd_reg <= pend_rd_next;
            pend_rw_reg <= pend_rw_next;
            pend_ri_reg <= pend_ri_next;
            pend_rv_reg <= pend_rv_next;
        end
        if (cmd.finish)
        begin
            out_rd_reg <= pend_rd_reg;
            out_rw_reg <= pend_rw_reg;
            out_ri_reg <= pend_ri_reg;
            out_rv_reg <= pend_rv_reg;
        end
    end

    assign sts.clr_last = (clr_cnt_reg == {AW{1'b1}});
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_rv_reg, out_ri_reg, out_rd_reg};
    assign m_tuser  = out_rw_reg;

endmodule

[rtl/core/vdp_host_port_top.sv]
// Flow: an accepted beat starts the memory read and fills the pending registers;
// when the output is free, the read-ahead and output registers load. No new beat
// is taken until then. Reset: rst_n async active low clears control state; then
// a clearing pass zeroes video memory with s_tready held low.
// Top level of the host port; depends on vdp_hp_pkg, vdp_hp_ctrl, vdp_hp_dp.
`timescale 1ns / 1ps

module vdp_host_port_top #(
    parameter int VRAM_DEPTH = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // write_data[7:0]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_data[7:0], reg_index[10:8], reg_value[18:11]
    output logic        m_tuser    // reg_written
);
    import vdp_hp_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    vdp_hp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    vdp_hp_dp #(
        .VRAM_DEPTH (VRAM_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .sts      (dp_sts),
        .in_cmd   (s_tuser),
        .in_data  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/vdp_hp_chk.sv]
// Port-level checks for the host port, bound to vdp_host_port_top.
// No package dependencies.
`timescale 1ns / 1ps

module vdp_hp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    a_one_beat_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing two cycles after beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_reg_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[23:8] == 16'd0)
        else $error("register fields set without register load");

endmodule

bind vdp_host_port_top vdp_hp_chk u_chk (.*);

[tb/tb.sv]
// Self-checking testbench for vdp_host_port_top: directed and random host accesses,
// with a scoreboard class that predicts every result beat.
// Depends on vdp_hp_pkg and the vdp_host_port_top RTL.
`timescale 1ns / 1ps

module tb;
    import vdp_hp_pkg::*;

    localparam int VRAM_DEPTH = 16384;
    localparam int RANDOM_ITEMS = 1300;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [7:0] read_data;
        logic       reg_written;
        logic [2:0] reg_index;
        logic [7:0] reg_value;
    } host_result_t;

    class host_port_scoreboard;
        logic [7:0]   vram [VRAM_DEPTH];
        logic [7:0]   mode_regs [8];
        logic [13:0]  ptr;
        logic [7:0]   prefetch;
        logic [7:0]   latch;
        logic [7:0]   status;
        logic         second;
        host_result_t expected_q [$];
        int           errors;

        function new();
            foreach (vram[i]) vram[i] = '0;
            foreach (mode_regs[i]) mode_regs[i] = '0;
            ptr = '0;
            prefetch = '0;
            latch = '0;
            status = '0;
            second = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int vidx(logic [13:0] p);
            return int'(p) & (VRAM_DEPTH - 1);
        endfunction

        function void note_access(logic [2:0] cmd, logic [7:0] d);
            host_result_t r;
            r = '0;
            case (cmd)
                CMD_RD_DATA:
                begin
                    second = 1'b0;
                    r.read_data = prefetch;
                    prefetch = vram[vidx(ptr)];
                    ptr = ptr + 14'd1;
                end
                CMD_RD_STATUS:
                begin
                    r.read_data = status;
                    status = status & STATUS_KEEP_MASK;
                    second = 1'b0;
                end
                CMD_WR_DATA:
                begin
                    second = 1'b0;
                    vram[vidx(ptr)] = d;
                    ptr = ptr + 14'd1;
                end
                CMD_WR_CTRL:
                begin
                    if (!second)
                    begin
                        latch = d;
                        second = 1'b1;
                    end
                    else
                    begin
                        if (d[BIT_REG_SEL])
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = d[RIDX_W-1:0];
                            r.reg_value = latch;
                            mode_regs[d[RIDX_W-1:0]] = latch;
                        end
                        else
                        begin
                            ptr = {d[ADDR_HI_W-1:0], latch};
                            if (!d[BIT_NO_PREFETCH])
                            begin
                                prefetch = vram[vidx(ptr)];
                                ptr = ptr + 14'd1;
                            end
                        end
                        second = 1'b0;
                    end
                end
                CMD_STS_EVENT: status = d;
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void flag(string field, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            if (errors <= 10)
                $display("%0t: %s expected %h got %h", $time, field, exp_v, act_v);
        endfunction

        function void check_result(logic [23:0] data, logic user);
            host_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result beat with none pending: tdata=%h tuser=%b",
                             $time, data, user);
                return;
            end
            e = expected_q.pop_front();
            if (data[7:0] !== e.read_data)
                flag("read_data", 32'(e.read_data), 32'(data[7:0]));
            if (user !== e.reg_written)
                flag("reg_written", 32'(e.reg_written), 32'(user));
            if (data[10:8] !== e.reg_index)
                flag("reg_index", 32'(e.reg_index), 32'(data[10:8]));
            if (data[18:11] !== e.reg_value)
                flag("reg_value", 32'(e.reg_value), 32'(data[18:11]));
            if (data[23:19] !== 5'd0)
                flag("tdata pad", 32'd0, 32'(data[23:19]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    host_port_scoreboard sb;
    bit calm;
    int n_sent;

    vdp_host_port_top #(
        .VRAM_DEPTH(VRAM_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
                sb.note_access(s_tuser, s_tdata);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    // result sink: random stall before each beat
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1) @(posedge clk);
            @(negedge clk);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send(logic [2:0] cmd, logic [7:0] d);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic set_address(logic [13:0] a, bit for_read);
        send(CMD_WR_CTRL, a[7:0]);
        send(CMD_WR_CTRL, {1'b0, ~for_read, a[13:8]});
    endtask

    task automatic run_random(int target);
        int          kind;
        int          len;
        logic [13:0] a;
        while (n_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            if ($urandom_range(0, 39) == 0)
                wait_drain();
            kind = $urandom_range(0, 99);
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0)
                a = 14'($urandom_range(0, 16383));
            else
                a = 14'(16'h3ff0 + $urandom_range(0, 31));
            if (kind < 80 && sb.second && $urandom_range(0, 7) != 0)
                send(CMD_RD_STATUS, 8'($urandom));
            if (kind < 30)
            begin
                set_address(a, 1'b0);
                repeat (len) send(CMD_WR_DATA, 8'($urandom));
            end
            else if (kind < 55)
            begin
                set_address(a, 1'b1);
                repeat (len) send(CMD_RD_DATA, 8'($urandom));
            end
            else if (kind < 70)
            begin
                send(CMD_WR_CTRL, 8'($urandom));
                send(CMD_WR_CTRL, 8'(1 << BIT_REG_SEL) | 8'($urandom_range(0, 127)));
            end
            else if (kind < 80)
            begin
                send(CMD_STS_EVENT, 8'($urandom));
                repeat ($urandom_range(1, 2)) send(CMD_RD_STATUS, 8'($urandom));
            end
            else
                send(3'($urandom_range(0, 7)), 8'($urandom));
        end
    endtask

    initial
    begin
        int tail;
        sb = new();
        calm = 1'b0;
        n_sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // status set and bit 7 cleared by a status read
        send(CMD_STS_EVENT, 8'hff);
        send(CMD_RD_STATUS, 8'h00);
        send(CMD_RD_STATUS, 8'h00);
        send(CMD_STS_EVENT, 8'h00);
        // write pointer at top of memory, then wrap to zero
        send(CMD_WR_CTRL, 8'hff);
        send(CMD_WR_CTRL, 8'h7f);
        send(CMD_WR_DATA, 8'haa);
        send(CMD_WR_DATA, 8'h55);
        // read address with prefetch across the wrap
        send(CMD_WR_CTRL, 8'hff);
        send(CMD_WR_CTRL, 8'h3f);
        send(CMD_RD_DATA, 8'hff);
        send(CMD_RD_DATA, 8'h00);
        // mode registers at both ends, ignored index bits set
        send(CMD_WR_CTRL, 8'hff);
        send(CMD_WR_CTRL, 8'hff);
        send(CMD_WR_CTRL, 8'h00);
        send(CMD_WR_CTRL, 8'h80);
        // status event between control bytes keeps the byte flag
        send(CMD_WR_CTRL, 8'h5a);
        send(CMD_STS_EVENT, 8'h80);
        send(CMD_WR_CTRL, 8'hfb);
        // status read between control bytes resets the byte flag
        send(CMD_WR_CTRL, 8'h12);
        send(CMD_RD_STATUS, 8'h00);
        send(CMD_WR_CTRL, 8'h34);
        send(CMD_WR_CTRL, 8'h40);
        send(CMD_UNUSED_LO, 8'hff);
        send(CMD_UNUSED_HI, 8'h00);

        wait_drain();
        run_random(n_sent + RANDOM_ITEMS);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        tail = 20;
        repeat (tail) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
rtl/core/vdp_hp_pkg.sv
rtl/core/vdp_hp_ctrl.sv
rtl/core/vdp_hp_dp.sv
rtl/core/vdp_host_port_top.sv
rtl/core/vdp_hp_chk.sv
tb/tb.sv
